### hdl/rmsd_pkg.sv
// ----------------------------------------------------------------------------
// rmsd_pkg
// Shared widths, reset values, command codes and result flag type of the
// running mean and standard deviation block.
// ----------------------------------------------------------------------------
package rmsd_pkg;

  localparam int COUNT_W = 11;
  localparam int GOAL_W = 11;
  localparam logic [GOAL_W-1:0] GOAL_RESET = 11'd10;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_PREEMPT = 1'b1;

  typedef struct packed {
    logic preempted;
    logic done_res;
  } flags_t;

endpackage

### hdl/rmsd_addsub.sv
// ----------------------------------------------------------------------------
// rmsd_addsub
// Shared add/subtract unit; carry out on subtract means a >= b.
// ----------------------------------------------------------------------------
module rmsd_addsub #(
  parameter int W = 54
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);

  logic [W-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_op} + (W+1)'(sub);

endmodule

### hdl/rmsd_core.sv
// ----------------------------------------------------------------------------
// rmsd_core
// Sequencer and datapath: accumulates count, sum and sum of squares, then
// forms n*sumsq - sum^2, its square root and both divisions by the count,
// one bit per cycle on the shared add/subtract unit.
// ----------------------------------------------------------------------------
module rmsd_core #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start_valid,
  output logic                           start_ready,
  input  logic                           command,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic [rmsd_pkg::GOAL_W-1:0]    goal,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [rmsd_pkg::COUNT_W-1:0]   res_count,
  output logic [SAMPLE_BITS-1:0]         res_echo,
  output logic [SAMPLE_BITS-1:0]         res_avg,
  output logic [SAMPLE_BITS-1:0]         res_dev,
  output rmsd_pkg::flags_t               res_flags
);

  localparam int SB = SAMPLE_BITS;
  localparam int CW = rmsd_pkg::COUNT_W;
  localparam int SW = SB + CW;
  localparam int QW = 2 * SB + CW;
  localparam int W = 2 * SW;
  localparam int RW = SW + 2;
  localparam int StepW = $clog2(SW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_MULN = 3'd2;
  localparam logic [2:0] S_MULS = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_DIVD = 3'd5;
  localparam logic [2:0] S_DIVM = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]        state;
  logic [CW-1:0]     count;
  logic [SW-1:0]     total;
  logic [QW-1:0]     sqtotal;
  logic [SB-1:0]     smp;
  logic [2*SB-1:0]   sq;
  logic [W-1:0]      acc;
  logic [W-1:0]      mq;
  logic [SW-1:0]     sr;
  logic [RW-1:0]     rem;
  logic [SW-1:0]     root;
  logic [SW-1:0]     dq;
  logic [CW-1:0]     drem;
  logic [StepW-1:0]  step;

  logic [W-1:0]      op_a;
  logic [W-1:0]      op_b;
  logic              op_sub;
  logic [W-1:0]      sum;
  logic              ge;
  logic [RW+1:0]     rem_sh;
  logic [RW-1:0]     trial;
  logic [CW:0]       d_sh;
  logic [SW-1:0]     root_next;
  logic [SW-1:0]     dq_next;
  logic              last;

  rmsd_addsub #(.W(W)) u_addsub (
    .a     (op_a),
    .b     (op_b),
    .sub   (op_sub),
    .sum   (sum),
    .carry (ge)
  );

  always_comb begin
    rem_sh = {rem, acc[W-1 -: 2]};
    trial = {root, 2'b01};
    d_sh = {drem, dq[SW-1]};
    op_a = '0;
    op_b = '0;
    op_sub = 1'b0;
    case (state)
      S_UPD: begin
        op_a = W'(sqtotal);
        op_b = W'(sq);
      end
      S_MULN: begin
        op_a = acc;
        op_b = mq;
      end
      S_MULS: begin
        op_a = acc;
        op_b = mq;
        op_sub = 1'b1;
      end
      S_SQRT: begin
        op_a = W'(rem_sh);
        op_b = W'(trial);
        op_sub = 1'b1;
      end
      S_DIVD, S_DIVM: begin
        op_a = W'(d_sh);
        op_b = W'(count);
        op_sub = 1'b1;
      end
      default: begin
        op_sub = 1'b0;
      end
    endcase
    root_next = {root[SW-2:0], ge};
    dq_next = {dq[SW-2:0], ge};
    last = (step == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
      sqtotal <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start_valid) begin
            if (command == rmsd_pkg::CMD_PREEMPT) begin
              res_count <= '0;
              res_echo <= '0;
              res_avg <= '0;
              res_dev <= '0;
              res_flags <= '{preempted: 1'b1, done_res: 1'b0};
              state <= S_FIN;
            end else if (count >= goal) begin
              count <= '0;
              total <= '0;
              sqtotal <= '0;
              res_count <= '0;
              res_echo <= '0;
              res_avg <= '0;
              res_dev <= '0;
              res_flags <= '{preempted: 1'b0, done_res: 1'b1};
              state <= S_FIN;
            end else begin
              smp <= sample;
              sq <= {{SB{1'b0}}, sample} * {{SB{1'b0}}, sample};
              count <= count + 1'b1;
              state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          sqtotal <= sum[QW-1:0];
          total <= total + SW'(smp);
          mq <= sum;
          acc <= '0;
          sr <= SW'(count);
          step <= StepW'(CW - 1);
          res_count <= count;
          res_echo <= smp;
          state <= S_MULN;
        end
        S_MULN, S_MULS: begin
          if (sr[0]) begin
            acc <= sum;
          end
          mq <= mq << 1;
          sr <= sr >> 1;
          if (last) begin
            step <= StepW'(SW - 1);
            if (state == S_MULN) begin
              mq <= W'(total);
              sr <= total;
              state <= S_MULS;
            end else begin
              rem <= '0;
              root <= '0;
              state <= S_SQRT;
            end
          end else begin
            step <= step - 1'b1;
          end
        end
        S_SQRT: begin
          acc <= acc << 2;
          rem <= ge ? sum[RW-1:0] : rem_sh[RW-1:0];
          root <= root_next;
          if (last) begin
            dq <= root_next;
            drem <= '0;
            step <= StepW'(SW - 1);
            state <= S_DIVD;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_DIVD, S_DIVM: begin
          drem <= ge ? sum[CW-1:0] : d_sh[CW-1:0];
          dq <= dq_next;
          if (last) begin
            if (state == S_DIVD) begin
              res_dev <= dq_next[SB-1:0];
              dq <= total;
              drem <= '0;
              step <= StepW'(SW - 1);
              state <= S_DIVM;
            end else begin
              res_avg <= dq_next[SB-1:0];
              res_flags <= '{preempted: 1'b0, done_res: (count >= goal)};
              if (count >= goal) begin
                count <= '0;
                total <= '0;
                sqtotal <= '0;
              end
              state <= S_FIN;
            end
          end else begin
            step <= step - 1'b1;
          end
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign start_ready = (state == S_IDLE);
  assign res_valid = (state == S_FIN);

  a_preempt_keeps: assert property (@(posedge clk) disable iff (rst)
    start_valid && start_ready && command == rmsd_pkg::CMD_PREEMPT
      |=> state == S_FIN && res_flags.preempted && $stable(count) && $stable(total))
    else $error("preempt changed accumulated state");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |-> !(res_flags.preempted && res_flags.done_res))
    else $error("result both done and preempted");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && res_flags.done_res |-> count == '0 && total == '0 && sqtotal == '0)
    else $error("done result left state behind");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_SQRT || state == S_DIVD |-> rem <= {1'b0, root, 1'b0})
    else $error("square root remainder out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIVD || state == S_DIVM |-> drem < count)
    else $error("division remainder not below count");

endmodule

### hdl/running_mean_std_dev.sv
// ----------------------------------------------------------------------------
// running_mean_std_dev
// Running mean and population standard deviation of a sample stream.
// ----------------------------------------------------------------------------
// Input items arrive on s_*: s_tuser is the command (0 sample, 1 preempt),
// s_tdata the unsigned Q0.SAMPLE_BITS sample. Each item yields exactly one
// result item on m_*: count, echoed sample, mean and standard deviation in
// m_tdata, done and preempted flags in m_tuser.
// cfg_* writes the sample goal (saturated to GOAL_MAX); it is always ready
// and must only be written while the block is idle.
// A sample runs on one shared add/subtract unit, one bit per cycle:
// 1 update, 11 steps for n*sumsq, then SAMPLE_BITS+11 steps each for sum^2,
// the square root and two divisions by the count, then the hand-over of the
// result. s_tready returns when the result is handed over, at the same edge
// where m_tvalid rises if the output register is free; a preempt or a
// dropped sample goes straight to the hand-over.
// s_tready is low while an item is in work.
// The result sits in an output register; a stalled receiver holds it there
// while the next item is already accepted, and the block waits with that
// next result until the register frees. Reset clears the count, sums,
// pending output and sets the goal to 10.
// ----------------------------------------------------------------------------
module running_mean_std_dev #(
  parameter int SAMPLE_BITS = 16,
  parameter int GOAL_MAX = 1024
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              s_tvalid,
  output logic                                              s_tready,
  // [SAMPLE_BITS-1:0] sample_value
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]                  s_tdata,
  // [0] command
  input  logic                                              s_tuser,
  output logic                                              m_tvalid,
  input  logic                                              m_tready,
  // sample_count, sample_echo, average, deviation from bit 0 up
  output logic [((rmsd_pkg::COUNT_W+3*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
  // [0] done_res, [1] preempted
  output logic [1:0]                                        m_tuser,
  input  logic                                              cfg_valid,
  output logic                                              cfg_ready,
  input  logic [rmsd_pkg::GOAL_W-1:0]                       cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int CW = rmsd_pkg::COUNT_W;
  localparam int GW = rmsd_pkg::GOAL_W;
  localparam int OutW = ((CW + 3 * SB + 7) / 8) * 8;
  localparam int GoalFull = (1 << GW) - 1;
  localparam int GoalCap = (GOAL_MAX > GoalFull) ? GoalFull : GOAL_MAX;

  logic [GW-1:0]     goal;
  logic [GW-1:0]     goal_eff;
  logic              res_valid;
  logic              res_ready;
  logic [CW-1:0]     res_count;
  logic [SB-1:0]     res_echo;
  logic [SB-1:0]     res_avg;
  logic [SB-1:0]     res_dev;
  rmsd_pkg::flags_t  res_flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal <= rmsd_pkg::GOAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      goal <= cfg_data;
    end
  end

  assign goal_eff = (goal > GW'(GoalCap)) ? GW'(GoalCap) : goal;

  rmsd_core #(.SAMPLE_BITS(SB)) u_core (
    .clk         (clk),
    .rst         (rst),
    .start_valid (s_tvalid),
    .start_ready (s_tready),
    .command     (s_tuser),
    .sample      (s_tdata[SB-1:0]),
    .goal        (goal_eff),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_count   (res_count),
    .res_echo    (res_echo),
    .res_avg     (res_avg),
    .res_dev     (res_dev),
    .res_flags   (res_flags)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= OutW'({res_dev, res_avg, res_echo, res_count});
      m_tuser <= {res_flags.preempted, res_flags.done_res};
    end
  end

endmodule

### verif/running_mean_std_dev_tb.sv
// ----------------------------------------------------------------------------
// running_mean_std_dev_tb
// Self-checking bench for the running mean and standard deviation block.
// Sample and preempt items go in through a queue-fed driver. Each accepted
// item is run through a bit-exact predictor of count, sums, mean and
// population deviation. Every result item is compared field by field with
// the oldest prediction. Goal settings cover the default, one, zero, a
// saturating value and the largest goal. Sender and receiver stall at random.
// ----------------------------------------------------------------------------
module running_mean_std_dev_tb;

  localparam int SAMPLE_BITS = 16;
  localparam int GOAL_MAX = 1024;
  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int RES_W = ((rmsd_pkg::COUNT_W + 3 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int SAMPLE_CYCLES = 4 * SAMPLE_BITS + 58;
  localparam int QUIET_LIMIT = 5000;

  typedef struct packed {
    logic                   cmd;
    logic [SAMPLE_BITS-1:0] value;
  } sample_item_t;

  typedef struct packed {
    logic [rmsd_pkg::COUNT_W-1:0] count;
    logic [SAMPLE_BITS-1:0]       echo;
    logic [SAMPLE_BITS-1:0]       average;
    logic [SAMPLE_BITS-1:0]       deviation;
    rmsd_pkg::flags_t             flags;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [RES_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rmsd_pkg::GOAL_W-1:0] cfg_data = '0;

  sample_item_t pending_samples[$];
  stats_t predicted_stats[$];
  logic offer_open = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  logic [rmsd_pkg::GOAL_W-1:0] goal_reg = rmsd_pkg::GOAL_RESET;
  logic [rmsd_pkg::COUNT_W-1:0] count_acc = '0;
  logic [25:0] sum_acc = '0;
  logic [41:0] square_acc = '0;

  running_mean_std_dev #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .GOAL_MAX(GOAL_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void clear_sums();
    count_acc = '0;
    sum_acc = '0;
    square_acc = '0;
  endfunction

  function automatic stats_t stats_after_item(sample_item_t it);
    stats_t r;
    logic [rmsd_pkg::GOAL_W-1:0] goal;
    logic [63:0] spread;
    logic [63:0] root;
    logic [63:0] cand;
    r = '0;
    goal = (goal_reg > GOAL_MAX) ? rmsd_pkg::GOAL_W'(GOAL_MAX) : goal_reg;
    if (it.cmd == rmsd_pkg::CMD_PREEMPT) begin
      r.flags.preempted = 1'b1;
      return r;
    end
    if (count_acc >= goal) begin
      clear_sums();
      r.flags.done_res = 1'b1;
      return r;
    end
    count_acc = count_acc + 1'b1;
    sum_acc = sum_acc + 26'(it.value);
    square_acc = square_acc + 42'(it.value) * 42'(it.value);
    spread = 64'(count_acc) * 64'(square_acc) - 64'(sum_acc) * 64'(sum_acc);
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= spread) begin
        root = cand;
      end
    end
    r.count = count_acc;
    r.echo = it.value;
    r.average = SAMPLE_BITS'(sum_acc / count_acc);
    r.deviation = SAMPLE_BITS'(root / count_acc);
    if (count_acc >= goal) begin
      r.flags.done_res = 1'b1;
      clear_sums();
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic void push_item(logic cmd, logic [SAMPLE_BITS-1:0] value);
    sample_item_t it;
    it.cmd = cmd;
    it.value = value;
    pending_samples = {pending_samples, it};
  endfunction

  function automatic void push_random_items(int n);
    logic [SAMPLE_BITS-1:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0: v = '0;
        1: v = '1;
        default: v = SAMPLE_BITS'($urandom);
      endcase
      push_item(($urandom_range(99) < 5) ? rmsd_pkg::CMD_PREEMPT : rmsd_pkg::CMD_SAMPLE, v);
    end
  endfunction

  task automatic drain();
    while (pending_samples.size() != 0 || offer_open || predicted_stats.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_goal(logic [rmsd_pkg::GOAL_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    goal_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // driver: hold the front item until taken
  always @(negedge clk) begin
    if (!offer_open && pending_samples.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      offer_open = 1'b1;
      s_tuser <= pending_samples[0].cmd;
      s_tdata <= DATA_W'(pending_samples[0].value);
    end
    s_tvalid <= offer_open;
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predicted_stats = {predicted_stats, stats_after_item(pending_samples.pop_front())};
      offer_open = 1'b0;
    end
  end

  always @(posedge clk) begin
    stats_t want;
    rmsd_pkg::flags_t got_flags;
    if (!rst && m_tvalid && m_tready) begin
      got_flags = m_tuser;
      if (predicted_stats.size() == 0) begin
        report_mismatch("unexpected result item", 1, 0);
      end else begin
        want = predicted_stats.pop_front();
        if (m_tdata[10:0] !== want.count)
          report_mismatch("sample_count", m_tdata[10:0], want.count);
        if (m_tdata[26:11] !== want.echo)
          report_mismatch("sample_echo", m_tdata[26:11], want.echo);
        if (m_tdata[42:27] !== want.average)
          report_mismatch("average", m_tdata[42:27], want.average);
        if (m_tdata[58:43] !== want.deviation)
          report_mismatch("deviation", m_tdata[58:43], want.deviation);
        if (got_flags.done_res !== want.flags.done_res)
          report_mismatch("done_res", got_flags.done_res, want.flags.done_res);
        if (got_flags.preempted !== want.flags.preempted)
          report_mismatch("preempted", got_flags.preempted, want.flags.preempted);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 32;
    recv_idle_pct = 78;

    // default goal of ten: run past it, with preempts in between
    push_item(rmsd_pkg::CMD_PREEMPT, '1);
    push_item(rmsd_pkg::CMD_SAMPLE, '0);
    push_item(rmsd_pkg::CMD_SAMPLE, '1);
    push_item(rmsd_pkg::CMD_SAMPLE, '1);
    push_item(rmsd_pkg::CMD_SAMPLE, 16'h0001);
    push_item(rmsd_pkg::CMD_PREEMPT, '0);
    push_item(rmsd_pkg::CMD_SAMPLE, 16'h8000);
    push_item(rmsd_pkg::CMD_SAMPLE, 16'hAAAA);
    push_item(rmsd_pkg::CMD_SAMPLE, 16'h5555);
    push_item(rmsd_pkg::CMD_SAMPLE, 16'h7FFF);
    push_item(rmsd_pkg::CMD_SAMPLE, 16'hFFFE);
    push_item(rmsd_pkg::CMD_SAMPLE, 16'h0000);
    push_item(rmsd_pkg::CMD_SAMPLE, 16'h1234);
    push_item(rmsd_pkg::CMD_SAMPLE, 16'hFFFF);
    push_item(rmsd_pkg::CMD_SAMPLE, 16'h0000);

    // goal below the count: drop one, then finish on every sample
    write_goal(rmsd_pkg::GOAL_W'(1));
    push_item(rmsd_pkg::CMD_SAMPLE, '1);
    push_item(rmsd_pkg::CMD_SAMPLE, '1);
    push_item(rmsd_pkg::CMD_SAMPLE, 16'h8001);

    write_goal('0);
    push_item(rmsd_pkg::CMD_SAMPLE, 16'h4321);
    push_item(rmsd_pkg::CMD_PREEMPT, '1);
    push_item(rmsd_pkg::CMD_SAMPLE, '0);

    // saturates to the largest goal
    write_goal('1);
    push_item(rmsd_pkg::CMD_SAMPLE, '1);
    push_item(rmsd_pkg::CMD_SAMPLE, '0);

    write_goal(rmsd_pkg::GOAL_W'($urandom_range(2, 40)));
    push_random_items(120);

    write_goal(rmsd_pkg::GOAL_W'($urandom_range(1, 16)));
    send_idle_pct = 78;
    recv_idle_pct = 32;
    push_random_items(120);

    write_goal(rmsd_pkg::GOAL_W'(GOAL_MAX));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random_items(140);

    drain();
    repeat (SAMPLE_CYCLES + 10) @(posedge clk);
    if (mismatch_count == 0 && predicted_stats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
